>>> rtl/tcur_pkg.sv
// Package for the touchpad relative cursor tracker.
// Holds the sequencer state type, register index codes and divider status.
// No dependencies.
package tcur_pkg;

  // APB address width: six 32-bit registers at byte address 4*i
  localparam int unsigned APB_AW = 5;

  // Register index codes (paddr[4:2])
  localparam logic [2:0] CFG_PAD_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_PAD_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_SCREEN_COLS = 3'd2;
  localparam logic [2:0] CFG_SCREEN_ROWS = 3'd3;
  localparam logic [2:0] CFG_START_X     = 3'd4;
  localparam logic [2:0] CFG_START_Y     = 3'd5;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_WAIT,
    ST_APPLY,
    ST_FIN
  } state_t;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/touchpad_relative_cursor_tracker_top.sv
// Touchpad relative cursor tracker, top level.
// A tracked sample (contact held) runs the sequencer states MUL, START, WAIT and APPLY
//   once per axis, x then y, with the bit-serial divider running in WAIT, then FIN; any
//   other sample goes from IDLE straight to FIN. FIN loads the result word when the output
//   is free, and a new sample is accepted only once the sequencer is back in IDLE.
// Reset (rst, synchronous): configuration registers to reset values, cursor at 0,0, no contact, idle.
module touchpad_relative_cursor_tracker_top #(
  parameter int PAD_BITS    = 12,
  parameter int SCREEN_BITS = 10
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // input words
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  input  logic [((2*PAD_BITS + 7) / 8) * 8 - 1:0]    s_tdata,  // pad_x, pad_y, zero fill
  input  logic [0:0]                                 s_tuser,  // touching
  // result words
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  output logic [((2*SCREEN_BITS + 7) / 8) * 8 - 1:0] m_tdata,  // cursor_x, cursor_y, zero fill
  output logic [0:0]                                 m_tuser,  // moved
  // configuration
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [tcur_pkg::APB_AW-1:0]                paddr,
  input  logic [31:0]                                pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready
);

  localparam int OUT_W = ((2*SCREEN_BITS + 7) / 8) * 8;
  localparam int Q_W   = PAD_BITS + SCREEN_BITS;   // |scaled| magnitude
  localparam int SC_W  = Q_W + 1;                  // signed scaled value
  localparam logic [PAD_BITS:0]    PAD_MAX = {1'b1, {PAD_BITS{1'b0}}};
  localparam logic [SCREEN_BITS:0] SCR_MAX = {1'b1, {SCREEN_BITS{1'b0}}};

  // config
  logic [PAD_BITS:0]      pad_width, pad_height;
  logic [SCREEN_BITS:0]   screen_cols, screen_rows;
  logic                   reload;
  logic [SCREEN_BITS-1:0] load_x, load_y;

  // tracking state
  tcur_pkg::state_t              state, state_next;
  logic                          in_contact;
  logic [SCREEN_BITS-1:0]        pos_x, pos_y;
  logic [PAD_BITS-1:0]           prev_x, prev_y;
  logic signed [PAD_BITS:0]      carry_x, carry_y;
  logic [PAD_BITS-1:0]           rx, ry;
  logic                          axis;
  logic                          moved;
  logic signed [SC_W-1:0]        scaled;

  // sequencer outputs
  logic                          div_start;
  logic                          out_load;
  logic                          accept;

  // divider
  tcur_pkg::div_stat_t           div_st;
  logic [Q_W-1:0]                div_quo;
  logic [PAD_BITS:0]             div_rem;
  logic [Q_W-1:0]                div_dvd;

  // datapath
  logic [PAD_BITS:0]             pw, ph, pad_sel;
  logic [SCREEN_BITS:0]          sw, sh, scr_sel, scr_dec;
  logic [SCREEN_BITS-1:0]        scr_m1, pos_sel, new_pos;
  logic                          sizes_ok, go_track;
  logic signed [PAD_BITS:0]      dx, dy, d_sel, carry_sel, r_s, new_carry;
  logic signed [SC_W:0]          prod, scaled_sum;
  logic [SC_W-1:0]               mag;
  logic                          neg;
  logic signed [Q_W:0]           q_s;
  logic signed [Q_W+1:0]         nxt;
  logic                          too_low, too_high;

  tcur_cfg #(
    .PAD_BITS    (PAD_BITS),
    .SCREEN_BITS (SCREEN_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pad_width   (pad_width),
    .pad_height  (pad_height),
    .screen_cols (screen_cols),
    .screen_rows (screen_rows),
    .reload      (reload),
    .load_x      (load_x),
    .load_y      (load_y)
  );

  tcur_div #(
    .DVD_W (Q_W),
    .DVS_W (PAD_BITS + 1)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (pad_sel),
    .stat      (div_st),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // effective sizes, oversized values saturate
  always_comb begin
    pw       = (pad_width   > PAD_MAX) ? PAD_MAX : pad_width;
    ph       = (pad_height  > PAD_MAX) ? PAD_MAX : pad_height;
    sw       = (screen_cols > SCR_MAX) ? SCR_MAX : screen_cols;
    sh       = (screen_rows > SCR_MAX) ? SCR_MAX : screen_rows;
    sizes_ok = (pw != '0) && (ph != '0) && (sw != '0) && (sh != '0);
    go_track = sizes_ok && s_tuser[0] && in_contact;
    accept   = s_tvalid && s_tready;
  end

  // per-axis operand select; y delta is inverted
  always_comb begin
    dx        = $signed({1'b0, rx}) - $signed({1'b0, prev_x});
    dy        = $signed({1'b0, prev_y}) - $signed({1'b0, ry});
    d_sel     = axis ? dy : dx;
    carry_sel = axis ? carry_y : carry_x;
    pad_sel   = axis ? ph : pw;
    scr_sel   = axis ? sh : sw;
    pos_sel   = axis ? pos_y : pos_x;
    scr_dec   = scr_sel - 1'b1;
    scr_m1    = scr_dec[SCREEN_BITS-1:0];
  end

  // scale: delta * (size - 1) + residual
  always_comb begin
    prod       = (SC_W+1)'(d_sel) * $signed({{(PAD_BITS+2){1'b0}}, scr_m1});
    scaled_sum = prod + (SC_W+1)'(carry_sel);
  end

  // magnitude into the divider, sign applied afterwards
  always_comb begin
    neg     = scaled[SC_W-1];
    mag     = neg ? -scaled : scaled;
    div_dvd = mag[Q_W-1:0];
  end

  // truncating quotient/remainder, move and clamp
  always_comb begin
    q_s      = neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    r_s      = neg ? -$signed(div_rem) : $signed(div_rem);
    nxt      = $signed({{(PAD_BITS+2){1'b0}}, pos_sel}) + (Q_W+2)'(q_s);
    too_low  = nxt[Q_W+1];
    too_high = nxt >= $signed({{(PAD_BITS+1){1'b0}}, scr_sel});
    if (too_low) begin
      new_pos   = '0;
      new_carry = '0;
    end else if (too_high) begin
      new_pos   = scr_m1;
      new_carry = '0;
    end else begin
      new_pos   = nxt[SCREEN_BITS-1:0];
      new_carry = r_s;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tcur_pkg::ST_IDLE:  if (accept) state_next = go_track ? tcur_pkg::ST_MUL
                                                             : tcur_pkg::ST_FIN;
      tcur_pkg::ST_MUL:   state_next = tcur_pkg::ST_START;
      tcur_pkg::ST_START: state_next = tcur_pkg::ST_WAIT;
      tcur_pkg::ST_WAIT:  if (div_st.done) state_next = tcur_pkg::ST_APPLY;
      tcur_pkg::ST_APPLY: state_next = axis ? tcur_pkg::ST_FIN : tcur_pkg::ST_MUL;
      tcur_pkg::ST_FIN:   if (out_load) state_next = tcur_pkg::ST_IDLE;
      default:            state_next = tcur_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = (state == tcur_pkg::ST_IDLE);
    div_start = (state == tcur_pkg::ST_START) && !div_st.busy;
    out_load  = (state == tcur_pkg::ST_FIN) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tcur_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // tracking state update
  always_ff @(posedge clk) begin
    if (rst) begin
      in_contact <= 1'b0;
      pos_x      <= '0;
      pos_y      <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      carry_x    <= '0;
      carry_y    <= '0;
    end else if (reload) begin
      in_contact <= 1'b0;
      pos_x      <= load_x;
      pos_y      <= load_y;
      prev_x     <= '0;
      prev_y     <= '0;
      carry_x    <= '0;
      carry_y    <= '0;
    end else if (accept && sizes_ok && !go_track) begin
      // release, or first sample of a contact
      carry_x    <= '0;
      carry_y    <= '0;
      in_contact <= s_tuser[0];
      if (s_tuser[0]) begin
        prev_x <= s_tdata[PAD_BITS-1:0];
        prev_y <= s_tdata[2*PAD_BITS-1:PAD_BITS];
      end
    end else if (state == tcur_pkg::ST_APPLY) begin
      if (axis) begin
        pos_y   <= new_pos;
        carry_y <= new_carry;
        prev_x  <= rx;
        prev_y  <= ry;
      end else begin
        pos_x   <= new_pos;
        carry_x <= new_carry;
      end
    end
  end

  // per-sample working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rx    <= s_tdata[PAD_BITS-1:0];
      ry    <= s_tdata[2*PAD_BITS-1:PAD_BITS];
      axis  <= 1'b0;
      moved <= 1'b0;
    end else if (state == tcur_pkg::ST_APPLY) begin
      axis  <= 1'b1;
      moved <= moved | (new_pos != pos_sel);
    end
    if (state == tcur_pkg::ST_MUL) scaled <= scaled_sum[SC_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata    <= OUT_W'({pos_y, pos_x});
      m_tuser[0] <= moved;
    end
  end

endmodule

>>> rtl/tcur_cfg.sv
// APB register file of the cursor tracker: pad and screen sizes, start point.
// Flags a reload of the cursor when a start register is written.
// Depends on tcur_pkg.
module tcur_cfg #(
  parameter int PAD_BITS    = 12,
  parameter int SCREEN_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcur_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [PAD_BITS:0]           pad_width,
  output logic [PAD_BITS:0]           pad_height,
  output logic [SCREEN_BITS:0]        screen_cols,
  output logic [SCREEN_BITS:0]        screen_rows,
  output logic                        reload,
  output logic [SCREEN_BITS-1:0]      load_x,
  output logic [SCREEN_BITS-1:0]      load_y
);

  logic [SCREEN_BITS-1:0] start_x;
  logic [SCREEN_BITS-1:0] start_y;
  logic [2:0]             idx;
  logic                   wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[tcur_pkg::APB_AW-1:2];
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_width   <= (PAD_BITS+1)'(4096);
      pad_height  <= (PAD_BITS+1)'(4096);
      screen_cols <= (SCREEN_BITS+1)'(320);
      screen_rows <= (SCREEN_BITS+1)'(240);
      start_x     <= '0;
      start_y     <= '0;
    end else if (wr_en) begin
      case (idx)
        tcur_pkg::CFG_PAD_WIDTH:   pad_width   <= pwdata[PAD_BITS:0];
        tcur_pkg::CFG_PAD_HEIGHT:  pad_height  <= pwdata[PAD_BITS:0];
        tcur_pkg::CFG_SCREEN_COLS: screen_cols <= pwdata[SCREEN_BITS:0];
        tcur_pkg::CFG_SCREEN_ROWS: screen_rows <= pwdata[SCREEN_BITS:0];
        tcur_pkg::CFG_START_X:     start_x     <= pwdata[SCREEN_BITS-1:0];
        tcur_pkg::CFG_START_Y:     start_y     <= pwdata[SCREEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // reload: start point as it stands after this write
  always_comb begin
    reload = wr_en && (idx == tcur_pkg::CFG_START_X || idx == tcur_pkg::CFG_START_Y);
    load_x = (idx == tcur_pkg::CFG_START_X) ? pwdata[SCREEN_BITS-1:0] : start_x;
    load_y = (idx == tcur_pkg::CFG_START_Y) ? pwdata[SCREEN_BITS-1:0] : start_y;
  end

  // read mux
  always_comb begin
    case (idx)
      tcur_pkg::CFG_PAD_WIDTH:   prdata = 32'(pad_width);
      tcur_pkg::CFG_PAD_HEIGHT:  prdata = 32'(pad_height);
      tcur_pkg::CFG_SCREEN_COLS: prdata = 32'(screen_cols);
      tcur_pkg::CFG_SCREEN_ROWS: prdata = 32'(screen_rows);
      tcur_pkg::CFG_START_X:     prdata = 32'(start_x);
      tcur_pkg::CFG_START_Y:     prdata = 32'(start_y);
      default:                   prdata = '0;
    endcase
  end

endmodule

>>> rtl/tcur_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Used for the x and then the y axis of each tracked sample.
// Depends on tcur_pkg.
module tcur_div #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DVS_W-1:0]     divisor,
  output tcur_pkg::div_stat_t  stat,
  output logic [DVD_W-1:0]     quotient,
  output logic [DVS_W-1:0]     remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  // one trial subtract per cycle
  always_comb begin
    shifted = {remainder, quotient[DVD_W-1]};
    ge      = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient shifts in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[DVD_W-2:0], ge};
      remainder <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> rtl/tcur_chk.sv
// Port-level checker for the cursor tracker, bound to the top level.
// Depends on tcur_pkg and touchpad_relative_cursor_tracker_top.
module tcur_chk #(
  parameter int PAD_BITS    = 12,
  parameter int SCREEN_BITS = 10
) (
  input logic                                       clk,
  input logic                                       rst,
  input logic                                       s_tvalid,
  input logic                                       s_tready,
  input logic [((2*PAD_BITS + 7) / 8) * 8 - 1:0]    s_tdata,  // pad_x, pad_y, zero fill
  input logic [0:0]                                 s_tuser,  // touching
  input logic                                       m_tvalid,
  input logic                                       m_tready,
  input logic [((2*SCREEN_BITS + 7) / 8) * 8 - 1:0] m_tdata,  // cursor_x, cursor_y, zero fill
  input logic [0:0]                                 m_tuser,  // moved
  input logic                                       psel,
  input logic                                       penable,
  input logic                                       pwrite,
  input logic [tcur_pkg::APB_AW-1:0]                paddr,
  input logic [31:0]                                pwdata,
  input logic [31:0]                                prdata,
  input logic                                       pready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // one sample at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a sample is in work");

  // fill bits above the two cursor fields stay zero
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata >> (2*SCREEN_BITS)) == '0)
    else $error("result fill bits not zero");

  // no register is read back wider than the pad size field
  a_rd_width: assert property (@(posedge clk) disable iff (rst)
    psel |-> (prdata >> (PAD_BITS + 1)) == '0)
    else $error("register read back out of width");

endmodule

bind touchpad_relative_cursor_tracker_top tcur_chk #(
  .PAD_BITS    (PAD_BITS),
  .SCREEN_BITS (SCREEN_BITS)
) u_tcur_chk (.*);
